FILE: src/dhfa_pkg.sv
`default_nettype none

package dhfa_pkg;

   localparam int ANG_W = 17;
   localparam int IH_W = 23;
   localparam int DIST_W = 39;
   localparam int HGT_W = 42;
   localparam int LVL_W = 2 * ANG_W + 1;

   localparam int FRAC_BITS_DEF = 16;
   localparam int NEAR_TERMS_DEF = 6;
   localparam int FAR_TERMS_DEF = 9;

   localparam logic [IH_W-1:0] IH_RESET = IH_W'(98304);

   typedef enum logic {
      OP_DIV,
      OP_MUL
   } op_type;

   typedef struct packed {
      logic   start;
      op_type op;
   } dhfa_cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ,
      ST_LEVEL,
      ST_LEVEL_WAIT,
      ST_TAN_WAIT,
      ST_DIST,
      ST_DIST_WAIT,
      ST_MUL,
      ST_MUL_WAIT,
      ST_HGT_SAT,
      ST_HGT_ADD,
      ST_DONE
   } state_type;

   function automatic int dhfa_max(int a, int b);
      return (a > b) ? a : b;
   endfunction

   function automatic int dhfa_a_width(int f);
      return dhfa_max(dhfa_max(IH_W + f, ANG_W + f), LVL_W);
   endfunction

   function automatic int dhfa_b_width(int f);
      return dhfa_max(ANG_W + f, DIST_W);
   endfunction

endpackage

`default_nettype wire

FILE: src/distance_height_from_angles.sv
// Sequence from acceptance to the result word: for each angle, a squaring step, a division
// for each term of the angle after the first and a final division for the tangent; then a
// distance division for the lower angle and, when the upper angle is given, a multiply,
// saturate and add for the height. An angle out of range sends the word straight to the result.
// Throughput: one word at a time, the next taken once the result is registered and the block is idle.
// Reset: synchronous, clears control and restores instrument height to 1.5 m.
`default_nettype none

module distance_height_from_angles
   import dhfa_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   parameter int NEAR_TERMS = NEAR_TERMS_DEF,
   parameter int FAR_TERMS = FAR_TERMS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [ANG_W-1:0]  req_low_angle,
   input  wire logic [ANG_W-1:0]  req_high_angle,
   input  wire logic              req_high_given,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [DIST_W-1:0]      rsp_distance,
   output logic [HGT_W-1:0]       rsp_height,
   output logic                   rsp_height_valid,
   output logic                   rsp_status,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [IH_W-1:0]   csr_data
);

   localparam int F = FRAC_BITS;
   localparam int A_W = dhfa_a_width(F);
   localparam int B_W = dhfa_b_width(F);
   localparam int RES_W = A_W + B_W;
   localparam int CNT_W = $clog2(A_W + 1);
   localparam int TAN_W = ANG_W + F;
   localparam int SQ_W = LVL_W - F;
   localparam int MAX_TERMS = dhfa_max(NEAR_TERMS, FAR_TERMS);
   localparam int ODD_W = $clog2(2 * MAX_TERMS);
   localparam int BK_W = ODD_W + F;
   localparam int CMP_LW = dhfa_max(BK_W, LVL_W);
   localparam int CMP_TW = dhfa_max(F + 1, LVL_W);
   localparam int CMP_AW = dhfa_max(ANG_W, F + 2);
   localparam int P_W = RES_W + 1;

   localparam logic [CMP_AW-1:0] SWITCH_ANGLE = CMP_AW'((7 << FRAC_BITS) / 10);
   localparam logic [CMP_AW-1:0] MAX_ANGLE = CMP_AW'((14 << FRAC_BITS) / 10);
   localparam logic [LVL_W-1:0]  HALF_SQ = LVL_W'(1) << (F - 1);
   localparam logic [P_W-1:0]    HALF_P = P_W'(1) << (F - 1);
   localparam logic [CMP_TW-1:0] ONE_T = CMP_TW'(1) << F;
   localparam logic [DIST_W-1:0] DIST_MAX = '1;
   localparam logic [HGT_W-1:0]  HGT_MAX = '1;
   localparam logic [ODD_W-1:0]  ODD_NEAR = ODD_W'(2 * NEAR_TERMS - 1);
   localparam logic [ODD_W-1:0]  ODD_FAR = ODD_W'(2 * FAR_TERMS - 1);
   localparam logic [CNT_W-1:0]  LVL_LEN = CNT_W'(LVL_W);
   localparam logic [CNT_W-1:0]  TAN_LEN = CNT_W'(TAN_W);
   localparam logic [CNT_W-1:0]  DIST_LEN = CNT_W'(IH_W + F);

   state_type          state_ff, state_in;
   logic [IH_W-1:0]    ih_ff, ih_in;
   logic [ANG_W-1:0]   hi_ff, hi_in;
   logic               given_ff, given_in;
   logic               which_ff, which_in;
   logic [ANG_W-1:0]   x_ff, x_in;
   logic [SQ_W-1:0]    sq_ff, sq_in;
   logic [LVL_W-1:0]   res_ff, res_in;
   logic [ODD_W-1:0]   odd_ff, odd_in;
   logic [TAN_W-1:0]   tan_ff, tan_in;
   logic [DIST_W-1:0]  dist_ff, dist_in;
   logic [HGT_W-1:0]   hgt_ff, hgt_in;
   logic               status_ff, status_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [DIST_W-1:0]  rsp_distance_ff, rsp_distance_in;
   logic [HGT_W-1:0]   rsp_height_ff, rsp_height_in;
   logic               rsp_height_valid_ff, rsp_height_valid_in;
   logic               rsp_status_ff, rsp_status_in;

   dhfa_cmd_type       cmd;
   logic [A_W-1:0]     op_a;
   logic [B_W-1:0]     op_b;
   logic [CNT_W-1:0]   op_len;
   logic               unit_done;
   logic [RES_W-1:0]   unit_result;

   logic               bad_lo, bad_hi;
   logic [LVL_W-1:0]   sq_full;
   logic [CMP_LW-1:0]  bk_x, res_lx;
   logic [CMP_TW-1:0]  res_tx;
   logic [P_W-1:0]     prod_p;
   logic [P_W-1:0]     prod_sh;
   logic               prod_ovf;
   logic [HGT_W:0]     hgt_sum;

   dhfa_unit #(
      .FRAC_BITS(FRAC_BITS)
   ) u_unit (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .op_a  (op_a),
      .op_b  (op_b),
      .op_len(op_len),
      .done  (unit_done),
      .result(unit_result)
   );

   always_comb begin
      bad_lo = (req_low_angle == '0) || (CMP_AW'(req_low_angle) > MAX_ANGLE);
      bad_hi = (req_high_angle == '0) || (CMP_AW'(req_high_angle) > MAX_ANGLE);
      sq_full = LVL_W'(x_ff * x_ff) + HALF_SQ;
      bk_x = CMP_LW'({odd_ff, F'(0)});
      res_lx = CMP_LW'(res_ff);
      res_tx = CMP_TW'(res_ff);
      prod_p = {1'b0, unit_result} + HALF_P;
      prod_ovf = (prod_p >> 64) != '0;
      prod_sh = prod_p >> F;
      hgt_sum = {1'b0, hgt_ff} + (HGT_W + 1)'(ih_ff);

      state_in = state_ff;
      ih_in = ih_ff;
      hi_in = hi_ff;
      given_in = given_ff;
      which_in = which_ff;
      x_in = x_ff;
      sq_in = sq_ff;
      res_in = res_ff;
      odd_in = odd_ff;
      tan_in = tan_ff;
      dist_in = dist_ff;
      hgt_in = hgt_ff;
      status_in = status_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_distance_in = rsp_distance_ff;
      rsp_height_in = rsp_height_ff;
      rsp_height_valid_in = rsp_height_valid_ff;
      rsp_status_in = rsp_status_ff;
      req_ready = 1'b0;
      cmd.start = 1'b0;
      cmd.op = OP_DIV;
      op_a = '0;
      op_b = '0;
      op_len = '0;

      if (csr_valid) begin
         ih_in = csr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               hi_in = req_high_angle;
               given_in = req_high_given;
               which_in = 1'b0;
               x_in = req_low_angle;
               dist_in = '0;
               hgt_in = '0;
               status_in = bad_lo || (req_high_given && bad_hi);
               state_in = (bad_lo || (req_high_given && bad_hi)) ? ST_DONE : ST_SQ;
            end
         end
         ST_SQ: begin
            sq_in = sq_full[LVL_W-1:F];
            odd_in = (CMP_AW'(x_ff) > SWITCH_ANGLE) ? ODD_FAR : ODD_NEAR;
            res_in = '0;
            state_in = ST_LEVEL;
         end
         ST_LEVEL: begin
            cmd.start = 1'b1;
            if (odd_ff == ODD_W'(1)) begin
               op_a = A_W'({x_ff, F'(0)});
               op_b = (ONE_T > res_tx) ? B_W'(ONE_T - res_tx) : B_W'(1);
               op_len = TAN_LEN;
               state_in = ST_TAN_WAIT;
            end else begin
               op_a = A_W'({sq_ff, F'(0)});
               op_b = (bk_x > res_lx) ? B_W'(bk_x - res_lx) : B_W'(1);
               op_len = LVL_LEN;
               state_in = ST_LEVEL_WAIT;
            end
         end
         ST_LEVEL_WAIT: begin
            if (unit_done) begin
               res_in = unit_result[LVL_W-1:0];
               odd_in = odd_ff - ODD_W'(2);
               state_in = ST_LEVEL;
            end
         end
         ST_TAN_WAIT: begin
            if (unit_done) begin
               tan_in = unit_result[TAN_W-1:0];
               state_in = which_ff ? ST_MUL : ST_DIST;
            end
         end
         ST_DIST: begin
            cmd.start = 1'b1;
            op_a = A_W'({ih_ff, F'(0)});
            op_b = B_W'(tan_ff);
            op_len = DIST_LEN;
            state_in = ST_DIST_WAIT;
         end
         ST_DIST_WAIT: begin
            if (unit_done) begin
               dist_in = (unit_result > RES_W'(DIST_MAX)) ? DIST_MAX
                                                         : unit_result[DIST_W-1:0];
               if (given_ff) begin
                  which_in = 1'b1;
                  x_in = hi_ff;
                  state_in = ST_SQ;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_MUL: begin
            cmd.start = 1'b1;
            cmd.op = OP_MUL;
            op_a = A_W'(tan_ff);
            op_b = B_W'(dist_ff);
            op_len = TAN_LEN;
            state_in = ST_MUL_WAIT;
         end
         ST_MUL_WAIT: begin
            if (unit_done) begin
               state_in = ST_HGT_SAT;
            end
         end
         ST_HGT_SAT: begin
            if (prod_ovf || (prod_sh > P_W'(HGT_MAX))) begin
               hgt_in = HGT_MAX;
            end else begin
               hgt_in = prod_sh[HGT_W-1:0];
            end
            state_in = ST_HGT_ADD;
         end
         ST_HGT_ADD: begin
            hgt_in = hgt_sum[HGT_W] ? HGT_MAX : hgt_sum[HGT_W-1:0];
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_distance_in = dist_ff;
               rsp_height_in = hgt_ff;
               rsp_height_valid_in = given_ff & ~status_ff;
               rsp_status_in = status_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      hi_ff <= hi_in;
      given_ff <= given_in;
      which_ff <= which_in;
      x_ff <= x_in;
      sq_ff <= sq_in;
      res_ff <= res_in;
      odd_ff <= odd_in;
      tan_ff <= tan_in;
      dist_ff <= dist_in;
      hgt_ff <= hgt_in;
      status_ff <= status_in;
      rsp_distance_ff <= rsp_distance_in;
      rsp_height_ff <= rsp_height_in;
      rsp_height_valid_ff <= rsp_height_valid_in;
      rsp_status_ff <= rsp_status_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         ih_ff <= IH_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ih_ff <= ih_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_distance = rsp_distance_ff;
   assign rsp_height = rsp_height_ff;
   assign rsp_height_valid = rsp_height_valid_ff;
   assign rsp_status = rsp_status_ff;

endmodule

`default_nettype wire

FILE: src/dhfa_unit.sv
`default_nettype none

module dhfa_unit
   import dhfa_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   localparam int A_W = dhfa_a_width(FRAC_BITS),
   localparam int B_W = dhfa_b_width(FRAC_BITS),
   localparam int RES_W = A_W + B_W,
   localparam int CNT_W = $clog2(A_W + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire dhfa_cmd_type     cmd,
   input  wire logic [A_W-1:0]   op_a,
   input  wire logic [B_W-1:0]   op_b,
   input  wire logic [CNT_W-1:0] op_len,
   output logic                  done,
   output logic [RES_W-1:0]      result
);

   localparam int IA_W = $clog2(A_W);

   op_type           op_ff, op_in;
   logic [A_W-1:0]   a_ff, a_in;
   logic [B_W-1:0]   b_ff, b_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [RES_W-1:0] acc_ff, acc_in;
   logic [B_W-1:0]   rem_ff, rem_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [CNT_W-1:0] cnt_m1;
   logic             bit_a;
   logic [B_W:0]     shifted;
   logic [B_W:0]     diff;
   logic             ge;

   always_comb begin
      cnt_m1  = cnt_ff - CNT_W'(1);
      bit_a   = a_ff[cnt_m1[IA_W-1:0]];
      shifted = {rem_ff, bit_a};
      diff    = shifted - {1'b0, b_ff};
      ge      = shifted >= {1'b0, b_ff};

      op_in   = op_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (cmd.start) begin
         op_in   = cmd.op;
         a_in    = op_a;
         b_in    = op_b;
         cnt_in  = op_len;
         acc_in  = '0;
         rem_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (op_ff == OP_DIV) begin
            rem_in = ge ? diff[B_W-1:0] : shifted[B_W-1:0];
            acc_in = {acc_ff[RES_W-2:0], ge};
         end else begin
            acc_in = {acc_ff[RES_W-2:0], 1'b0} + (bit_a ? RES_W'(b_ff) : RES_W'(0));
         end
         cnt_in = cnt_m1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done   = done_ff;
   assign result = acc_ff;

endmodule

`default_nettype wire
